FILE: rtl/wfcs_pkg.sv
package wfcs_pkg;

  localparam int MAX_RESULTS = 64;
  localparam int CNT_W = 7;

  localparam logic [1:0] REQ_FILE = 2'd0;
  localparam logic [1:0] REQ_ACK  = 2'd1;
  localparam logic [1:0] REQ_TICK = 2'd2;

  localparam logic [1:0] CFG_SESSION_IDLE = 2'd0;
  localparam logic [1:0] CFG_RESEND_IDLE  = 2'd1;
  localparam logic [1:0] CFG_MAX_ATTEMPTS = 2'd2;
  localparam logic [1:0] CFG_CHUNK_BYTES  = 2'd3;

  typedef enum logic [2:0] {
    KIND_SEND        = 3'd0,
    KIND_RESEND      = 3'd1,
    KIND_FINISHED    = 3'd2,
    KIND_IGN_ACTIVE  = 3'd3,
    KIND_NOT_FOUND   = 3'd4,
    KIND_NO_SLOT     = 3'd5,
    KIND_NO_SESSION  = 3'd6,
    KIND_UNMATCHED   = 3'd7
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_REQ_RD,
    ST_REQ_EV,
    ST_REQ_DEC,
    ST_FILL,
    ST_WB,
    ST_ACK_RD,
    ST_ACK_EV,
    ST_ACK_SRD,
    ST_ACK_SEV,
    ST_ACK_DEC,
    ST_TICK_SRD,
    ST_TICK_SEV,
    ST_TICK_WRD,
    ST_TICK_WEV,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] client_addr;
    logic [15:0] client_port;
    logic [31:0] req_offset;
    logic [31:0] req_size;
    logic [31:0] file_length;
    logic        file_exists;
    logic [47:0] now_us;
  } in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  session_index;
    logic [31:0] out_addr;
    logic [15:0] out_port;
    logic [31:0] chunk_offset;
    logic [15:0] chunk_size;
    logic [31:0] out_file_length;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [47:0] session_idle_us;
    logic [47:0] resend_idle_us;
    logic [3:0]  max_resend_attempts;
    logic [15:0] chunk_bytes;
  } cfg_t;

  typedef struct packed {
    logic [31:0] addr;
    logic [15:0] port;
    logic [47:0] last_access;
    logic [31:0] next_offset;
    logic [31:0] remaining;
    logic [31:0] file_length;
  } sess_rec_t;

  typedef struct packed {
    logic [31:0] offset;
    logic [15:0] size;
    logic [47:0] sent_time;
    logic [3:0]  attempts;
  } slot_rec_t;

  typedef struct packed {
    logic emit;
    logic finish;
    out_t res;
  } res_cmd_t;

  function automatic out_t mk_res(input kind_e kind, input logic [2:0] idx,
                                  input logic [31:0] addr, input logic [15:0] port,
                                  input logic [31:0] off, input logic [15:0] size,
                                  input logic [31:0] flen);
    out_t r;
    r.kind            = kind;
    r.session_index   = idx;
    r.out_addr        = addr;
    r.out_port        = port;
    r.chunk_offset    = off;
    r.chunk_size      = size;
    r.out_file_length = flen;
    r.last            = 1'b0;
    return r;
  endfunction

endpackage

FILE: rtl/windowed_file_chunk_sender_unit.sv
// Windowed chunk sender: a selective-repeat sender with a table of client
// sessions, each owning a window of outstanding chunk transfers.
// The input channel (in_valid, in_ready, in_item) takes one beat per file
// request, acknowledgement or timer tick. The output channel (out_valid,
// out_ready, out_item) gives the results of that beat in order; the final
// result of each input beat carries last. Some beats give no result.
// Items are handled one at a time: in_ready is high only while the engine
// is idle. Each table lives in a memory with one registered read port, so
// every session or window slot that a scan reads takes an address state,
// then an evaluate and write-back state.
// The last result is held back one place until the next arrives, so a
// receiver stall only stops the engine when both the held result and the
// output register are full. The next beat is accepted while the final
// result still waits in the output register.
// Reset clears all session and slot valid bits and loads the configuration
// defaults; the tables need no clearing pass. Users write configuration
// through cfg_we, cfg_index and cfg_data while idle; nothing enforces it.
module windowed_file_chunk_sender_unit #(
  parameter int SESSIONS = 8,
  parameter int WINDOW = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  wfcs_pkg::in_t  in_item,
  output logic           out_valid,
  input  logic           out_ready,
  output wfcs_pkg::out_t out_item,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [47:0]    cfg_data
);

  localparam int SW = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;
  localparam int KW = (SESSIONS * WINDOW > 1) ? $clog2(SESSIONS * WINDOW) : 1;

  wfcs_pkg::cfg_t      cfg;
  wfcs_pkg::res_cmd_t  cmd;
  logic                room;
  logic                sess_we, slot_we;
  logic [SW-1:0]       sess_waddr, sess_raddr;
  logic [KW-1:0]       slot_waddr, slot_raddr;
  wfcs_pkg::sess_rec_t sess_wdata, sess_rdata;
  wfcs_pkg::slot_rec_t slot_wdata, slot_rdata;

  // Configuration registers, written without handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.session_idle_us     <= 48'd10000000;
      cfg.resend_idle_us      <= 48'd500000;
      cfg.max_resend_attempts <= 4'd10;
      cfg.chunk_bytes         <= 16'd1024;
    end else if (cfg_we) begin
      case (cfg_index)
        wfcs_pkg::CFG_SESSION_IDLE: cfg.session_idle_us     <= cfg_data;
        wfcs_pkg::CFG_RESEND_IDLE:  cfg.resend_idle_us      <= cfg_data;
        wfcs_pkg::CFG_MAX_ATTEMPTS: cfg.max_resend_attempts <= cfg_data[3:0];
        wfcs_pkg::CFG_CHUNK_BYTES:  cfg.chunk_bytes         <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // The engine scans both tables and owns the valid bits.
  wfcs_engine #(.SESSIONS(SESSIONS), .WINDOW(WINDOW)) u_engine (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .room       (room),
    .cmd        (cmd),
    .sess_we    (sess_we),
    .sess_waddr (sess_waddr),
    .sess_wdata (sess_wdata),
    .sess_raddr (sess_raddr),
    .sess_rdata (sess_rdata),
    .slot_we    (slot_we),
    .slot_waddr (slot_waddr),
    .slot_wdata (slot_wdata),
    .slot_raddr (slot_raddr),
    .slot_rdata (slot_rdata)
  );

  // Session table: one record per client session.
  wfcs_ram #(.DEPTH(SESSIONS), .WIDTH($bits(wfcs_pkg::sess_rec_t))) u_sess_ram (
    .clk   (clk),
    .we    (sess_we),
    .waddr (sess_waddr),
    .wdata (sess_wdata),
    .raddr (sess_raddr),
    .rdata (sess_rdata)
  );

  // Window table: one record per outstanding chunk, session-major.
  wfcs_ram #(.DEPTH(SESSIONS * WINDOW), .WIDTH($bits(wfcs_pkg::slot_rec_t))) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  // Output register with one result held back to place the last flag.
  wfcs_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

FILE: rtl/wfcs_ram.sv
module wfcs_ram #(
  parameter int DEPTH = 8,
  parameter int WIDTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/wfcs_out_stage.sv
module wfcs_out_stage (
  input  logic                clk,
  input  logic                rst,
  input  wfcs_pkg::res_cmd_t  cmd,
  output logic                room,
  output logic                out_valid,
  input  logic                out_ready,
  output wfcs_pkg::out_t      out_item
);

  // One result is held back until the next one arrives or the item ends,
  // so that the final result can be marked.
  logic           hold_valid;
  wfcs_pkg::out_t hold;

  assign room = !hold_valid || !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.emit && room) begin
        if (hold_valid) begin
          out_item  <= hold;
          out_valid <= 1'b1;
        end
        hold       <= cmd.res;
        hold_valid <= 1'b1;
      end else if (cmd.finish && room && hold_valid) begin
        out_item      <= hold;
        out_item.last <= 1'b1;
        out_valid     <= 1'b1;
        hold_valid    <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/wfcs_engine.sv
module wfcs_engine #(
  parameter int SESSIONS = 8,
  parameter int WINDOW = 8,
  localparam int SW = (SESSIONS > 1) ? $clog2(SESSIONS) : 1,
  localparam int WW = (WINDOW > 1) ? $clog2(WINDOW) : 1,
  localparam int KW = (SESSIONS * WINDOW > 1) ? $clog2(SESSIONS * WINDOW) : 1
) (
  input  logic                clk,
  input  logic                rst,
  input  wfcs_pkg::cfg_t      cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  wfcs_pkg::in_t       in_item,
  input  logic                room,
  output wfcs_pkg::res_cmd_t  cmd,
  output logic                sess_we,
  output logic [SW-1:0]       sess_waddr,
  output wfcs_pkg::sess_rec_t sess_wdata,
  output logic [SW-1:0]       sess_raddr,
  input  wfcs_pkg::sess_rec_t sess_rdata,
  output logic                slot_we,
  output logic [KW-1:0]       slot_waddr,
  output wfcs_pkg::slot_rec_t slot_wdata,
  output logic [KW-1:0]       slot_raddr,
  input  wfcs_pkg::slot_rec_t slot_rdata
);

  wfcs_pkg::state_e    state, state_next;
  wfcs_pkg::in_t       item;
  wfcs_pkg::sess_rec_t cur;
  logic [SW-1:0]       s, cur_s, pick;
  logic [WW-1:0]       w;
  logic                found, found_act, pick_found;
  logic [SESSIONS-1:0] sess_valid, clr_mask;
  logic [SESSIONS*WINDOW-1:0] slot_active;
  logic [wfcs_pkg::CNT_W-1:0] count;

  logic [KW-1:0] k;
  logic          s_last, w_last, s_match, s_active, slot_hit, slot_due, cap;
  logic          sess_busy, over, stall;
  logic [47:0]   sess_age, slot_age;
  logic [15:0]   fill_sz;
  logic [31:0]   new_rem;

  assign k          = KW'(int'(cur_s) * WINDOW + int'(w));
  assign s_last     = (s == SW'(SESSIONS - 1));
  assign w_last     = (w == WW'(WINDOW - 1));
  assign sess_raddr = s;
  assign slot_raddr = k;

  assign sess_age = item.now_us - sess_rdata.last_access;
  assign slot_age = item.now_us - slot_rdata.sent_time;
  assign s_match  = sess_valid[s] && (sess_rdata.addr == item.client_addr)
                    && (sess_rdata.port == item.client_port);
  assign s_active = sess_valid[s] && (sess_age < cfg.session_idle_us);
  assign slot_hit = slot_active[k] && (slot_rdata.offset == item.req_offset)
                    && ({16'd0, slot_rdata.size} == item.req_size);
  assign slot_due = slot_active[k] && (slot_age > cfg.resend_idle_us)
                    && (slot_rdata.attempts <= cfg.max_resend_attempts);
  assign cap      = (count == wfcs_pkg::CNT_W'(wfcs_pkg::MAX_RESULTS));
  assign sess_busy = |slot_active[int'(cur_s) * WINDOW +: WINDOW];

  assign fill_sz = (cur.remaining > {16'd0, cfg.chunk_bytes}) ? cfg.chunk_bytes
                                                              : cur.remaining[15:0];

  // Requested range clamped to the end of the file.
  assign over = ({1'b0, item.req_offset} + {1'b0, item.req_size}) > {1'b0, item.file_length};
  assign new_rem = !over ? item.req_size :
                   (item.req_offset > item.file_length) ? 32'd0
                                                        : item.file_length - item.req_offset;

  assign stall = cmd.emit && !room;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      wfcs_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (in_item.req_type)
            wfcs_pkg::REQ_FILE: state_next = wfcs_pkg::ST_REQ_RD;
            wfcs_pkg::REQ_ACK:  state_next = wfcs_pkg::ST_ACK_RD;
            wfcs_pkg::REQ_TICK: state_next = wfcs_pkg::ST_TICK_SRD;
            default:            state_next = wfcs_pkg::ST_FIN;
          endcase
        end
      end
      wfcs_pkg::ST_REQ_RD: state_next = wfcs_pkg::ST_REQ_EV;
      wfcs_pkg::ST_REQ_EV: state_next = s_last ? wfcs_pkg::ST_REQ_DEC : wfcs_pkg::ST_REQ_RD;
      wfcs_pkg::ST_REQ_DEC: begin
        if ((found && found_act) || !item.file_exists || !pick_found) begin
          state_next = wfcs_pkg::ST_FIN;
        end else begin
          state_next = wfcs_pkg::ST_FILL;
        end
      end
      wfcs_pkg::ST_FILL: begin
        if (!stall && w_last) begin
          state_next = wfcs_pkg::ST_WB;
        end
      end
      wfcs_pkg::ST_WB: state_next = wfcs_pkg::ST_FIN;
      wfcs_pkg::ST_ACK_RD: state_next = wfcs_pkg::ST_ACK_EV;
      wfcs_pkg::ST_ACK_EV: begin
        if (s_match) begin
          state_next = wfcs_pkg::ST_ACK_SRD;
        end else begin
          state_next = s_last ? wfcs_pkg::ST_FIN : wfcs_pkg::ST_ACK_RD;
        end
      end
      wfcs_pkg::ST_ACK_SRD: state_next = wfcs_pkg::ST_ACK_SEV;
      wfcs_pkg::ST_ACK_SEV: begin
        if (slot_hit) begin
          state_next = wfcs_pkg::ST_ACK_DEC;
        end else begin
          state_next = w_last ? wfcs_pkg::ST_FIN : wfcs_pkg::ST_ACK_SRD;
        end
      end
      wfcs_pkg::ST_ACK_DEC: begin
        state_next = (cur.remaining != 32'd0) ? wfcs_pkg::ST_FILL : wfcs_pkg::ST_FIN;
      end
      wfcs_pkg::ST_TICK_SRD: state_next = wfcs_pkg::ST_TICK_SEV;
      wfcs_pkg::ST_TICK_SEV: begin
        if (s_active) begin
          state_next = wfcs_pkg::ST_TICK_WRD;
        end else begin
          state_next = s_last ? wfcs_pkg::ST_FIN : wfcs_pkg::ST_TICK_SRD;
        end
      end
      wfcs_pkg::ST_TICK_WRD: state_next = wfcs_pkg::ST_TICK_WEV;
      wfcs_pkg::ST_TICK_WEV: begin
        if (cap) begin
          state_next = wfcs_pkg::ST_FIN;
        end else if (!stall) begin
          if (!w_last) begin
            state_next = wfcs_pkg::ST_TICK_WRD;
          end else begin
            state_next = s_last ? wfcs_pkg::ST_FIN : wfcs_pkg::ST_TICK_SRD;
          end
        end
      end
      wfcs_pkg::ST_FIN: begin
        if (room) begin
          state_next = wfcs_pkg::ST_IDLE;
        end
      end
      default: state_next = wfcs_pkg::ST_IDLE;
    endcase
  end

  // Strobes towards the memories and the output stage.
  always_comb begin
    in_ready   = (state == wfcs_pkg::ST_IDLE);
    cmd        = '0;
    sess_we    = 1'b0;
    sess_waddr = cur_s;
    sess_wdata = cur;
    sess_wdata.last_access = item.now_us;
    slot_we    = 1'b0;
    slot_waddr = k;
    slot_wdata = slot_rdata;
    case (state)
      wfcs_pkg::ST_REQ_DEC: begin
        if (found && found_act) begin
          cmd.emit = 1'b1;
          cmd.res  = wfcs_pkg::mk_res(wfcs_pkg::KIND_IGN_ACTIVE, 3'(cur_s), item.client_addr,
                                      item.client_port, 32'd0, 16'd0, 32'd0);
        end else if (!item.file_exists) begin
          cmd.emit = 1'b1;
          cmd.res  = wfcs_pkg::mk_res(wfcs_pkg::KIND_NOT_FOUND, 3'd0, item.client_addr,
                                      item.client_port, 32'd0, 16'd0, 32'd0);
        end else if (!pick_found) begin
          cmd.emit = 1'b1;
          cmd.res  = wfcs_pkg::mk_res(wfcs_pkg::KIND_NO_SLOT, 3'd0, item.client_addr,
                                      item.client_port, 32'd0, 16'd0, 32'd0);
        end
      end
      wfcs_pkg::ST_FILL: begin
        if (!slot_active[k]) begin
          cmd.emit = 1'b1;
          cmd.res  = wfcs_pkg::mk_res(wfcs_pkg::KIND_SEND, 3'(cur_s), cur.addr, cur.port,
                                      cur.next_offset, fill_sz, cur.file_length);
          slot_we  = room;
          slot_wdata.offset    = cur.next_offset;
          slot_wdata.size      = fill_sz;
          slot_wdata.sent_time = item.now_us;
          slot_wdata.attempts  = 4'd0;
        end
      end
      wfcs_pkg::ST_WB: sess_we = 1'b1;
      wfcs_pkg::ST_ACK_EV: begin
        if (!s_match && s_last) begin
          cmd.emit = 1'b1;
          cmd.res  = wfcs_pkg::mk_res(wfcs_pkg::KIND_NO_SESSION, 3'd0, item.client_addr,
                                      item.client_port, 32'd0, 16'd0, 32'd0);
        end
      end
      wfcs_pkg::ST_ACK_SEV: begin
        if (!slot_hit && w_last) begin
          cmd.emit = 1'b1;
          cmd.res  = wfcs_pkg::mk_res(wfcs_pkg::KIND_UNMATCHED, 3'(cur_s), item.client_addr,
                                      item.client_port, 32'd0, 16'd0, 32'd0);
        end
      end
      wfcs_pkg::ST_ACK_DEC: begin
        if (cur.remaining == 32'd0 && !sess_busy) begin
          cmd.emit = 1'b1;
          cmd.res  = wfcs_pkg::mk_res(wfcs_pkg::KIND_FINISHED, 3'(cur_s), item.client_addr,
                                      item.client_port, 32'd0, 16'd0, 32'd0);
        end
      end
      wfcs_pkg::ST_TICK_WEV: begin
        if (!cap && slot_due) begin
          cmd.emit = 1'b1;
          cmd.res  = wfcs_pkg::mk_res(wfcs_pkg::KIND_RESEND, 3'(cur_s), cur.addr, cur.port,
                                      slot_rdata.offset, slot_rdata.size, cur.file_length);
          slot_we  = room;
          slot_wdata.sent_time = item.now_us;
          slot_wdata.attempts  = (slot_rdata.attempts == 4'hF) ? 4'hF
                                                               : slot_rdata.attempts + 4'd1;
        end
      end
      wfcs_pkg::ST_FIN: cmd.finish = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= wfcs_pkg::ST_IDLE;
      sess_valid  <= '0;
      slot_active <= '0;
    end else begin
      state <= state_next;
      if (cmd.emit && !stall) begin
        count <= count + 1'b1;
      end
      case (state)
        wfcs_pkg::ST_IDLE: begin
          if (in_valid) begin
            item       <= in_item;
            s          <= '0;
            w          <= '0;
            count      <= '0;
            found      <= 1'b0;
            found_act  <= 1'b0;
            pick_found <= 1'b0;
            clr_mask   <= '0;
          end
        end
        wfcs_pkg::ST_REQ_EV: begin
          if (s_match && !found) begin
            found     <= 1'b1;
            found_act <= s_active;
            cur_s     <= s;
          end
          if (!s_active || s_match) begin
            clr_mask[s] <= 1'b1;
            if (!pick_found) begin
              pick       <= s;
              pick_found <= 1'b1;
            end
          end
          if (!s_last) begin
            s <= s + 1'b1;
          end
        end
        wfcs_pkg::ST_REQ_DEC: begin
          if (!(found && found_act) && item.file_exists) begin
            for (int i = 0; i < SESSIONS; i++) begin
              if (clr_mask[i]) begin
                sess_valid[i] <= 1'b0;
                slot_active[i * WINDOW +: WINDOW] <= '0;
              end
            end
            if (pick_found) begin
              sess_valid[pick]  <= 1'b1;
              cur.addr          <= item.client_addr;
              cur.port          <= item.client_port;
              cur.last_access   <= item.now_us;
              cur.next_offset   <= item.req_offset;
              cur.remaining     <= new_rem;
              cur.file_length   <= item.file_length;
              cur_s             <= pick;
              w                 <= '0;
            end
          end
        end
        wfcs_pkg::ST_FILL: begin
          if (!stall) begin
            if (!slot_active[k]) begin
              slot_active[k]  <= 1'b1;
              cur.remaining   <= cur.remaining - {16'd0, fill_sz};
              cur.next_offset <= cur.next_offset + {16'd0, fill_sz};
            end
            if (!w_last) begin
              w <= w + 1'b1;
            end
          end
        end
        wfcs_pkg::ST_ACK_EV: begin
          if (s_match) begin
            cur   <= sess_rdata;
            cur_s <= s;
            w     <= '0;
          end else if (!s_last) begin
            s <= s + 1'b1;
          end
        end
        wfcs_pkg::ST_ACK_SEV: begin
          if (slot_hit) begin
            slot_active[k] <= 1'b0;
          end else if (!w_last) begin
            w <= w + 1'b1;
          end
        end
        wfcs_pkg::ST_ACK_DEC: begin
          if (cur.remaining == 32'd0 && !sess_busy) begin
            sess_valid[cur_s] <= 1'b0;
          end
          w <= '0;
        end
        wfcs_pkg::ST_TICK_SEV: begin
          if (s_active) begin
            cur   <= sess_rdata;
            cur_s <= s;
            w     <= '0;
          end else if (!s_last) begin
            s <= s + 1'b1;
          end
        end
        wfcs_pkg::ST_TICK_WEV: begin
          if (!cap && !stall) begin
            if (!w_last) begin
              w <= w + 1'b1;
            end else if (!s_last) begin
              s <= s + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/wfcs_check.sv
module wfcs_check (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_ready,
  input wfcs_pkg::in_t  in_item,
  input logic           out_valid,
  input logic           out_ready,
  input wfcs_pkg::out_t out_item
);

  // A stalled result beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result beat changed while stalled");

  // Leaving reset, the block is idle and shows no result.
  a_reset: assert property (@(posedge clk) rst |=> !out_valid && in_ready)
    else $error("block not idle after reset");

  // Every kind other than send and resend is the only result of its beat.
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.kind != wfcs_pkg::KIND_SEND
    && out_item.kind != wfcs_pkg::KIND_RESEND |-> out_item.last)
    else $error("status result without last");

  // Status results carry no chunk description.
  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.kind != wfcs_pkg::KIND_SEND
    && out_item.kind != wfcs_pkg::KIND_RESEND
    |-> out_item.chunk_offset == 32'd0 && out_item.chunk_size == 16'd0
        && out_item.out_file_length == 32'd0)
    else $error("status result with chunk fields");

  // An accepted beat leaves in_ready low in the following cycle.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second beat taken back to back");

endmodule

bind windowed_file_chunk_sender_unit wfcs_check u_check (.*);
